// ===== design/tequ_pkg.sv =====
package tequ_pkg;

   localparam int QueueDepthDefault = 32;
   localparam int TypeCountDefault  = 32;

   localparam logic [1:0] FUNC_SCHEDULE   = 2'd0;
   localparam logic [1:0] FUNC_UNSCHEDULE = 2'd1;
   localparam logic [1:0] FUNC_ADVANCE    = 2'd2;

   localparam logic [1:0] KIND_FIRED       = 2'd0;
   localparam logic [1:0] KIND_SCHED_DONE  = 2'd1;
   localparam logic [1:0] KIND_UNSCHED_DONE = 2'd2;
   localparam logic [1:0] KIND_ADV_DONE    = 2'd3;

   localparam logic [30:0] LATE_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic       load;
      logic       ins;
      logic       find;
      logic       rem;
      logic       pop;
      logic       emit;
      logic [1:0] emit_kind;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic due;
      logic handler0;
   } status_type;

endpackage

// ===== design/tequ_ctrl.sv =====
module tequ_ctrl
   import tequ_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_func,
   output logic       req_stall,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   input  status_type sts,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCHED,
      ST_FIND,
      ST_REMOVE,
      ST_ADV
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_func)
                  FUNC_SCHEDULE:   state_in = ST_SCHED;
                  FUNC_UNSCHEDULE: state_in = ST_FIND;
                  FUNC_ADVANCE:    state_in = ST_ADV;
                  default:         state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCHED: begin
            if (out_free) begin
               cmd.ins       = !sts.full;
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_SCHED_DONE;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_FIND: begin
            cmd.find = 1'b1;
            state_in = ST_REMOVE;
         end
         ST_REMOVE: begin
            if (out_free) begin
               cmd.rem       = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_UNSCHED_DONE;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_ADV: begin
            if (sts.due) begin
               // silent pop for types without a handler
               if (!sts.handler0) begin
                  cmd.pop = 1'b1;
               end else if (out_free) begin
                  cmd.pop       = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_FIRED;
                  rsp_valid_in  = 1'b1;
               end
            end else if (out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_ADV_DONE;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/tequ_datapath.sv =====
module tequ_datapath
   import tequ_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault,
   parameter int TYPE_COUNT  = TypeCountDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         sts,
   input  logic [63:0]        req_now_us,
   input  logic signed [31:0] req_delay_us,
   input  logic [4:0]         req_kind_id,
   input  logic [63:0]        req_user_word,
   input  logic               csr_write_enable,
   input  logic [31:0]        csr_write_data,
   output logic [1:0]         rsp_result_kind,
   output logic [4:0]         rsp_fired_type,
   output logic [63:0]        rsp_fired_data,
   output logic [30:0]        rsp_lateness_us,
   output logic [63:0]        rsp_next_delay_us,
   output logic               rsp_has_next,
   output logic               rsp_flag,
   output logic               rsp_rejected,
   output logic               rsp_last
);

   localparam int OW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);

   logic [63:0] time_ff [QUEUE_DEPTH];
   logic [4:0]  type_ff [QUEUE_DEPTH];
   logic [63:0] data_ff [QUEUE_DEPTH];
   logic [63:0] time_in [QUEUE_DEPTH];
   logic [4:0]  type_in [QUEUE_DEPTH];
   logic [63:0] data_in [QUEUE_DEPTH];

   logic [OW-1:0] occ_ff, occ_in;
   logic [31:0]   mask_ff;
   logic [63:0]   now_ff, t_ff, word_ff;
   logic [4:0]    kind_ff;
   logic [IW-1:0] idx_ff, idx_in;
   logic          found_ff, found_in;

   logic [QUEUE_DEPTH-1:0] lt, match;
   logic          empty, earliest;
   logic [63:0]   late_diff, next_diff;
   logic [30:0]   late_sat;

   logic [1:0]  kind_out_ff;
   logic [4:0]  ftype_ff;
   logic [63:0] fdata_ff, next_ff;
   logic [30:0] late_ff;
   logic        has_next_ff, flag_ff, rej_ff, last_ff;

   assign empty     = (occ_ff == '0);
   assign earliest  = empty || (time_ff[0] > t_ff);
   assign late_diff = now_ff - time_ff[0];
   assign next_diff = time_ff[0] - now_ff;
   assign late_sat  = (|late_diff[63:31]) ? LATE_MAX : late_diff[30:0];

   assign sts.full     = (occ_ff == OW'(QUEUE_DEPTH));
   assign sts.due      = !empty && (time_ff[0] <= now_ff);
   assign sts.handler0 = ({1'b0, type_ff[0]} < 6'(TYPE_COUNT)) && mask_ff[type_ff[0]];

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         lt[i]    = (OW'(i) < occ_ff) && (time_ff[i] < t_ff);
         match[i] = (OW'(i) < occ_ff) && (type_ff[i] == kind_ff) && (data_ff[i] == word_ff);
      end
   end

   // highest matching slot has the latest time
   always_comb begin
      idx_in   = '0;
      found_in = |match;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (match[i]) idx_in = IW'(i);
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         time_in[i] = time_ff[i];
         type_in[i] = type_ff[i];
         data_in[i] = data_ff[i];
         if (cmd.ins && !lt[i]) begin
            if (i == 0 || lt[(i == 0) ? 0 : i-1]) begin
               time_in[i] = t_ff;
               type_in[i] = kind_ff;
               data_in[i] = word_ff;
            end else begin
               time_in[i] = time_ff[(i == 0) ? 0 : i-1];
               type_in[i] = type_ff[(i == 0) ? 0 : i-1];
               data_in[i] = data_ff[(i == 0) ? 0 : i-1];
            end
         end else if (i < QUEUE_DEPTH - 1 &&
                      (cmd.pop || (cmd.rem && found_ff && IW'(i) >= idx_ff))) begin
            time_in[i] = time_ff[(i < QUEUE_DEPTH - 1) ? i+1 : i];
            type_in[i] = type_ff[(i < QUEUE_DEPTH - 1) ? i+1 : i];
            data_in[i] = data_ff[(i < QUEUE_DEPTH - 1) ? i+1 : i];
         end
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (cmd.ins) occ_in = occ_ff + OW'(1);
      else if (cmd.pop || (cmd.rem && found_ff)) occ_in = occ_ff - OW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= '0;
         mask_ff <= '0;
      end else begin
         occ_ff <= occ_in;
         if (csr_write_enable) mask_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         time_ff[i] <= time_in[i];
         type_ff[i] <= type_in[i];
         data_ff[i] <= data_in[i];
      end
      if (cmd.load) begin
         now_ff  <= req_now_us;
         t_ff    <= req_now_us + 64'(req_delay_us);
         kind_ff <= req_kind_id;
         word_ff <= req_user_word;
      end
      if (cmd.find) begin
         idx_ff   <= idx_in;
         found_ff <= found_in;
      end
      if (cmd.emit) begin
         kind_out_ff <= cmd.emit_kind;
         ftype_ff    <= '0;
         fdata_ff    <= '0;
         late_ff     <= '0;
         next_ff     <= '0;
         has_next_ff <= 1'b0;
         flag_ff     <= 1'b0;
         rej_ff      <= 1'b0;
         last_ff     <= 1'b1;
         case (cmd.emit_kind)
            KIND_FIRED: begin
               ftype_ff <= type_ff[0];
               fdata_ff <= data_ff[0];
               late_ff  <= late_sat;
               last_ff  <= 1'b0;
            end
            KIND_SCHED_DONE: begin
               flag_ff <= !sts.full && earliest;
               rej_ff  <= sts.full;
            end
            KIND_UNSCHED_DONE: flag_ff <= found_ff;
            KIND_ADV_DONE: begin
               has_next_ff <= !empty;
               next_ff     <= empty ? 64'd0 : next_diff;
            end
            default: last_ff <= 1'b1;
         endcase
      end
   end

   assign rsp_result_kind   = kind_out_ff;
   assign rsp_fired_type    = ftype_ff;
   assign rsp_fired_data    = fdata_ff;
   assign rsp_lateness_us   = late_ff;
   assign rsp_next_delay_us = next_ff;
   assign rsp_has_next      = has_next_ff;
   assign rsp_flag          = flag_ff;
   assign rsp_rejected      = rej_ff;
   assign rsp_last          = last_ff;

endmodule

// ===== design/timed_event_queue_unit.sv =====
// from the accepting edge to a registered result: schedule loads the request, then inserts;
// unschedule scans for a match, then shifts; advance pops each due event, then reports the end
// one transaction at a time: the next is accepted only once the final result is registered;
// a waiting result stalls progress
// synchronous active-high reset empties the queue and clears the handler mask
// slot contents are not reset; only slots below the occupancy count are ever read
module timed_event_queue_unit
   import tequ_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault,
   parameter int TYPE_COUNT  = TypeCountDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [63:0]        req_now_us,
   input  logic signed [31:0] req_delay_us,
   input  logic [4:0]         req_kind_id,
   input  logic [63:0]        req_user_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_result_kind,
   output logic [4:0]         rsp_fired_type,
   output logic [63:0]        rsp_fired_data,
   output logic [30:0]        rsp_lateness_us,
   output logic [63:0]        rsp_next_delay_us,
   output logic               rsp_has_next,
   output logic               rsp_flag,
   output logic               rsp_rejected,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic [31:0]        csr_write_data
);

   cmd_type    cmd;
   status_type sts;

   tequ_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   tequ_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TYPE_COUNT  (TYPE_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_now_us        (req_now_us),
      .req_delay_us      (req_delay_us),
      .req_kind_id       (req_kind_id),
      .req_user_word     (req_user_word),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_fired_type    (rsp_fired_type),
      .rsp_fired_data    (rsp_fired_data),
      .rsp_lateness_us   (rsp_lateness_us),
      .rsp_next_delay_us (rsp_next_delay_us),
      .rsp_has_next      (rsp_has_next),
      .rsp_flag          (rsp_flag),
      .rsp_rejected      (rsp_rejected),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== dv/tb_timed_event_queue_unit.sv =====
`timescale 1ns / 100ps

module tb_timed_event_queue_unit;
   import tequ_pkg::*;

   localparam int Depth = QueueDepthDefault;
   localparam int TypeCount = TypeCountDefault;
   localparam longint CycleLimit = 400000;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [4:0]  fired_type;
      logic [63:0] fired_data;
      logic [30:0] lateness_us;
      logic [63:0] next_delay_us;
      logic        has_next;
      logic        flag;
      logic        rejected;
      logic        last;
   } event_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_func = '0;
   logic [63:0] req_now_us = '0;
   logic signed [31:0] req_delay_us = '0;
   logic [4:0] req_kind_id = '0;
   logic [63:0] req_user_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_result_kind;
   logic [4:0] rsp_fired_type;
   logic [63:0] rsp_fired_data;
   logic [30:0] rsp_lateness_us;
   logic [63:0] rsp_next_delay_us;
   logic rsp_has_next;
   logic rsp_flag;
   logic rsp_rejected;
   logic rsp_last;
   logic csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;

   timed_event_queue_unit uut (.*);

   always #2 clock = ~clock;

   // predictor state
   logic [63:0] pend_time[Depth];
   logic [4:0]  pend_type[Depth];
   logic [63:0] pend_data[Depth];
   int          pend_count;
   logic [31:0] mask_shadow;

   event_result_type expected_results[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   longint cycle_count = 0;
   logic [63:0] clock_now = 64'd1000;

   function automatic event_result_type blank_result(input logic [1:0] kind);
      event_result_type r;
      r = '0;
      r.result_kind = kind;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic queue_expected(input event_result_type r);
      expected_results = {expected_results, r};
   endtask

   task automatic drop_entry(input int idx);
      for (int i = idx; i + 1 < pend_count; i++) begin
         pend_time[i] = pend_time[i + 1];
         pend_type[i] = pend_type[i + 1];
         pend_data[i] = pend_data[i + 1];
      end
      pend_count--;
   endtask

   task automatic predict_events(input logic [1:0] func, input logic [63:0] now,
                                 input logic signed [31:0] delay, input logic [4:0] kind,
                                 input logic [63:0] word);
      event_result_type r;
      logic [63:0] t;
      logic [63:0] late;
      int pos;
      bit found;
      if (func == FUNC_SCHEDULE) begin
         r = blank_result(KIND_SCHED_DONE);
         if (pend_count >= Depth) begin
            r.rejected = 1'b1;
         end else begin
            t = now + {{32{delay[31]}}, delay};
            r.flag = (pend_count == 0) || (pend_time[0] > t);
            pos = 0;
            while (pos < pend_count && pend_time[pos] < t) pos++;
            for (int i = pend_count; i > pos; i--) begin
               pend_time[i] = pend_time[i - 1];
               pend_type[i] = pend_type[i - 1];
               pend_data[i] = pend_data[i - 1];
            end
            pend_time[pos] = t;
            pend_type[pos] = kind;
            pend_data[pos] = word;
            pend_count++;
         end
         queue_expected(r);
      end else if (func == FUNC_UNSCHEDULE) begin
         found = 0;
         for (int i = pend_count - 1; i >= 0 && !found; i--) begin
            if (pend_type[i] == kind && pend_data[i] == word) begin
               drop_entry(i);
               found = 1;
            end
         end
         r = blank_result(KIND_UNSCHED_DONE);
         r.flag = found;
         queue_expected(r);
      end else if (func == FUNC_ADVANCE) begin
         while (pend_count > 0 && pend_time[0] <= now) begin
            r = '0;
            r.result_kind = KIND_FIRED;
            r.fired_type = pend_type[0];
            r.fired_data = pend_data[0];
            late = now - pend_time[0];
            r.lateness_us = (late > 64'(LATE_MAX)) ? LATE_MAX : late[30:0];
            if (int'(pend_type[0]) < TypeCount && mask_shadow[pend_type[0]])
               queue_expected(r);
            drop_entry(0);
         end
         r = blank_result(KIND_ADV_DONE);
         if (pend_count > 0) begin
            r.has_next = 1'b1;
            r.next_delay_us = pend_time[0] - now;
         end
         queue_expected(r);
      end
   endtask

   // valid stays up after the accepting edge; the next send replaces the command, an idle cycle or a drain drops it
   task automatic send_command(input logic [1:0] func, input logic [63:0] now,
                               input logic signed [31:0] delay, input logic [4:0] kind,
                               input logic [63:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      predict_events(func, now, delay, kind, word);
      req_valid <= 1'b1;
      req_func <= func;
      req_now_us <= now;
      req_delay_us <= delay;
      req_kind_id <= kind;
      req_user_word <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_mask(input logic [31:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mask_shadow = value;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      event_result_type got;
      event_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_result_kind, rsp_fired_type, rsp_fired_data, rsp_lateness_us,
                   rsp_next_delay_us, rsp_has_next, rsp_flag, rsp_rejected, rsp_last};
            if (expected_results.size() == 0) begin
               $error("unexpected transaction kind %0d", got.result_kind);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.result_kind !== want.result_kind) begin
                  $error("result_kind exp %0d got %0d", want.result_kind, got.result_kind);
                  error_count++;
               end
               if (got.fired_type !== want.fired_type) begin
                  $error("fired_type exp %0d got %0d", want.fired_type, got.fired_type);
                  error_count++;
               end
               if (got.fired_data !== want.fired_data) begin
                  $error("fired_data exp %h got %h", want.fired_data, got.fired_data);
                  error_count++;
               end
               if (got.lateness_us !== want.lateness_us) begin
                  $error("lateness_us exp %0d got %0d", want.lateness_us, got.lateness_us);
                  error_count++;
               end
               if (got.next_delay_us !== want.next_delay_us) begin
                  $error("next_delay_us exp %h got %h", want.next_delay_us,
                         got.next_delay_us);
                  error_count++;
               end
               if (got.has_next !== want.has_next) begin
                  $error("has_next exp %0d got %0d", want.has_next, got.has_next);
                  error_count++;
               end
               if (got.flag !== want.flag) begin
                  $error("flag exp %0d got %0d", want.flag, got.flag);
                  error_count++;
               end
               if (got.rejected !== want.rejected) begin
                  $error("rejected exp %0d got %0d", want.rejected, got.rejected);
                  error_count++;
               end
               if (got.last !== want.last) begin
                  $error("last exp %0d got %0d", want.last, got.last);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic test_directed();
      // fill to full, then one rejected
      write_mask(32'hFFFF_FFFF);
      for (int i = 0; i < Depth; i++)
         send_command(FUNC_SCHEDULE, clock_now, 32'(i % 5) - 2, 5'(i),
                      {$urandom, $urandom});
      send_command(FUNC_SCHEDULE, clock_now, 32'sd10, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF);
      send_command(FUNC_ADVANCE, clock_now, 0, 0, 0);
      // duplicates for the unschedule tie rule, mask extremes
      write_mask(32'h0000_0000);
      send_command(FUNC_SCHEDULE, clock_now, 32'sd100, 5'd7, 64'hA5);
      send_command(FUNC_SCHEDULE, clock_now, 32'sd100, 5'd7, 64'hA5);
      send_command(FUNC_SCHEDULE, clock_now, 32'sd50, 5'd7, 64'hA5);
      send_command(FUNC_UNSCHEDULE, clock_now, 0, 5'd7, 64'hA5);
      send_command(FUNC_UNSCHEDULE, clock_now, 0, 5'd8, 64'hA5);
      send_command(FUNC_ADVANCE, clock_now + 200, 0, 0, 0);
      write_mask(32'h8000_0001);
      // extreme delays and wrapping times
      send_command(FUNC_SCHEDULE, 64'hFFFF_FFFF_FFFF_FFF0, 32'h7FFF_FFFF, 5'd0, 64'h1);
      send_command(FUNC_SCHEDULE, 64'd5, 32'h8000_0000, 5'd31, 64'h2);
      send_command(FUNC_SCHEDULE, 64'd0, 32'sd0, 5'd3, 64'h0);
      send_command(2'd3, 64'd0, 0, 0, 0);
      send_command(FUNC_ADVANCE, 64'h0000_0001_0000_0000, 0, 0, 0);
      send_command(FUNC_ADVANCE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
      clock_now = 64'd5000;
   endtask

   task automatic test_random(input int count, input int idle_pct, input int st_pct);
      logic [63:0] word;
      logic [4:0] kind;
      int pick;
      send_idle_pct = idle_pct;
      stall_pct = st_pct;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         kind = 5'($urandom_range(7));
         word = 64'($urandom_range(3));
         if ($urandom_range(9) == 0) begin
            kind = 5'($urandom);
            word = {$urandom, $urandom};
         end
         if (pick < 50)
            send_command(FUNC_SCHEDULE, clock_now,
                         ($urandom_range(19) == 0) ? 32'($urandom) :
                         32'($urandom_range(300)) - 50, kind, word);
         else if (pick < 70)
            send_command(FUNC_UNSCHEDULE, clock_now, $urandom, kind, word);
         else if (pick < 97) begin
            clock_now = clock_now + $urandom_range(150);
            send_command(FUNC_ADVANCE, clock_now, $urandom, 5'($urandom),
                         {$urandom, $urandom});
         end else
            send_command(2'd3, {$urandom, $urandom}, $urandom, 5'($urandom),
                         {$urandom, $urandom});
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      pend_count = 0;
      mask_shadow = '0;
      @(posedge clock);
      test_directed();
      write_mask($urandom);
      test_random(100, 0, 0);
      write_mask(32'hFFFF_FFFF);
      test_random(100, 80, 0);
      write_mask($urandom);
      test_random(100, 0, 80);
      write_mask(32'h5555_AAAA);
      test_random(64, 22, 22);
      wait_drained();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== timed_event_queue_unit.f =====
design/tequ_pkg.sv
design/tequ_ctrl.sv
design/tequ_datapath.sv
design/timed_event_queue_unit.sv
dv/tb_timed_event_queue_unit.sv
